// ===== rtl/core/pmfs_pkg.sv =====
// Shared constants and command codes for the point-mass friction step core.
`timescale 1ns / 1ps
`default_nettype none
package pmfs_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SETPOS = 2'd1;
    localparam logic [1:0] CMD_FORCE = 2'd2;
    localparam logic [1:0] CMD_SETACC = 2'd3;
    localparam logic [1:0] REG_MASS = 2'd0;
    localparam logic [1:0] REG_FRIC = 2'd1;
    localparam logic [1:0] REG_VMAX = 2'd2;
    localparam logic [1:0] REG_VMIN = 2'd3;
    localparam logic [27:0] GRAVITY_Q24 = 28'd164416717;
    localparam logic [30:0] MASS_RST = 31'd65536;
    localparam logic [30:0] VMAX_RST = 31'd32768000;
    localparam logic signed [31:0] VMIN_RST = -32'sd32768000;
endpackage
`default_nettype wire

// ===== rtl/core/point_mass_friction_step_core.sv =====
// Top level of the point-mass friction step core.
`timescale 1ns / 1ps
`default_nettype none
// Takes one command word at a time and returns one result word per command.
// Set position and set acceleration go straight to the output state; apply
// force runs two 128-step restoring divides. A tick with zero velocity skips
// the friction steps, one in which friction stops the mass skips the divides,
// and any other tick runs a 32-step square root, two 64-step restoring divides
// and a few multiplies, all on one shared multiplier.
// The next command can be taken as soon as the result is valid. Input
// ready is low while a command is worked; a finished result waits in the output
// register until it is taken.
module point_mass_friction_step_core
    import pmfs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [79:0]  s_tdata,  // dt, value_x, value_y
    input  wire  [1:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  wire          m_tready,
    // pos_x_out, pos_y_out, prev_x_out, prev_y_out, vel_x_out, vel_y_out
    output logic [191:0] m_tdata,
    input  wire          cfg_we,
    input  wire  [1:0]   cfg_index,
    input  wire  [31:0]  cfg_wdata
);
    localparam logic [3:0] ST_IDLE = 4'd0, ST_FMUL = 4'd1, ST_SQ = 4'd2,
        ST_SQRT = 4'd3, ST_BMUL = 4'd4, ST_DIV = 4'd5, ST_BRK = 4'd6,
        ST_ACC = 4'd7, ST_POS = 4'd8, ST_FDIV = 4'd9, ST_FAPP = 4'd10,
        ST_OUT = 4'd11, ST_CLAMP = 4'd12;

    logic [30:0] mass_reg, fric_reg, vmax_reg;
    logic signed [31:0] vmin_reg;
    logic signed [31:0] px_reg, py_reg, qx_reg, qy_reg, vx_reg, vy_reg, ax_reg, ay_reg;
    logic [3:0] st_reg;
    logic [15:0] dt_reg;
    logic signed [31:0] ix_reg, iy_reg;
    logic signed [47:0] wvx_reg, wvy_reg;
    logic [63:0] fm_reg, spd_reg;
    logic [63:0] n_reg, r_reg, b_reg;
    logic [127:0] num_reg;
    logic [63:0] den_reg, rem_reg, quo_reg;
    logic [6:0] cnt_reg;
    logic ax_sel_reg;
    logic [1:0] sub_reg;

    // shared multiplier: signed 34 x 33
    logic signed [33:0] ma;
    logic signed [32:0] mb;
    logic signed [66:0] mp;
    assign mp = ma * mb;

    function automatic logic signed [47:0] rnd_dt(input logic signed [66:0] p);
        logic signed [66:0] t;
        t = p + 67'sd32768;
        return t[63:16];
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [48:0] v);
        if (v > 49'sd2147483647) return 32'sh7fffffff;
        if (v < -49'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    logic [63:0] absx, absy, cur_abs;
    assign absx = wvx_reg[47] ? 64'(-wvx_reg) : 64'(wvx_reg);
    assign absy = wvy_reg[47] ? 64'(-wvy_reg) : 64'(wvy_reg);
    assign cur_abs = ax_sel_reg ? absy : absx;

    logic signed [47:0] cur_v;
    assign cur_v = ax_sel_reg ? wvy_reg : wvx_reg;

    logic signed [47:0] vmax_s, vmin_s;
    assign vmax_s = $signed({17'd0, vmax_reg});
    assign vmin_s = 48'(vmin_reg);

    always_comb begin
        ma = '0;
        mb = '0;
        case (st_reg)
            ST_FMUL: begin
                if (sub_reg == 2'd0) begin
                    ma = 34'(fric_reg);
                    mb = 33'(dt_reg);
                end else begin
                    ma = 34'(fm_reg);
                    mb = 33'(GRAVITY_Q24);
                end
            end
            ST_SQ: begin
                ma = 34'(cur_abs);
                mb = 33'(cur_abs);
            end
            ST_BMUL: begin
                ma = 34'(fm_reg);
                mb = 33'(cur_abs);
            end
            ST_ACC, ST_FAPP: begin
                ma = ax_sel_reg ? 34'(ay_reg) : 34'(ax_reg);
                mb = 33'(dt_reg);
            end
            ST_POS: begin
                ma = 34'(cur_v);
                mb = 33'(dt_reg);
            end
            default: ;
        endcase
    end

    assign s_tready = (st_reg == ST_IDLE);

    logic [64:0] trial;
    assign trial = {rem_reg, num_reg[127]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_reg <= MASS_RST; fric_reg <= '0; vmax_reg <= VMAX_RST;
            vmin_reg <= VMIN_RST;
            px_reg <= '0; py_reg <= '0; qx_reg <= '0; qy_reg <= '0;
            vx_reg <= '0; vy_reg <= '0; ax_reg <= '0; ay_reg <= '0;
            st_reg <= ST_IDLE; m_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MASS: mass_reg <= cfg_wdata[30:0];
                    REG_FRIC: fric_reg <= cfg_wdata[30:0];
                    REG_VMAX: vmax_reg <= cfg_wdata[30:0];
                    default:  vmin_reg <= cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready && st_reg != ST_OUT) m_tvalid <= 1'b0;
            case (st_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        dt_reg <= s_tdata[15:0];
                        ix_reg <= s_tdata[47:16]; iy_reg <= s_tdata[79:48];
                        ax_sel_reg <= 1'b0; sub_reg <= '0;
                        wvx_reg <= 48'(vx_reg); wvy_reg <= 48'(vy_reg);
                        case (s_tuser)
                            CMD_TICK: st_reg <= (vx_reg != 0 || vy_reg != 0)
                                ? ST_FMUL : ST_ACC;
                            CMD_SETPOS: begin
                                px_reg <= s_tdata[47:16]; py_reg <= s_tdata[79:48];
                                st_reg <= ST_OUT;
                            end
                            CMD_SETACC: begin
                                ax_reg <= s_tdata[47:16]; ay_reg <= s_tdata[79:48];
                                st_reg <= ST_OUT;
                            end
                            default: begin
                                cnt_reg <= '0; st_reg <= ST_FDIV;
                                ax_reg <= '0; ay_reg <= '0;
                                rem_reg <= '0;
                                den_reg <= 64'(mass_reg);
                                num_reg <= {64'd0, 64'(s_tdata[47] ?
                                    -33'($signed(s_tdata[47:16])) :
                                    33'($signed(s_tdata[47:16]))) << FRAC_BITS};
                            end
                        endcase
                    end
                end
                ST_FMUL: begin
                    if (sub_reg == 2'd0) begin
                        fm_reg <= 64'(mp[63:0] + 64'd32768) >> 16;
                        sub_reg <= 2'd1;
                    end else begin
                        fm_reg <= 64'(mp[63:0] + 64'd8388608) >> 24;
                        sub_reg <= '0; n_reg <= '0; st_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    n_reg <= n_reg + 64'(mp[63:0]);
                    if (ax_sel_reg) begin
                        ax_sel_reg <= 1'b0; st_reg <= ST_SQRT;
                        r_reg <= '0; b_reg <= 64'd1 << 62;
                    end else ax_sel_reg <= 1'b1;
                end
                ST_SQRT: begin
                    if (b_reg == 0) begin
                        spd_reg <= r_reg;
                        if (fm_reg >= r_reg) begin
                            wvx_reg <= '0; wvy_reg <= '0; st_reg <= ST_ACC;
                        end else st_reg <= ST_BMUL;
                    end else begin
                        if (n_reg >= r_reg + b_reg) begin
                            n_reg <= n_reg - (r_reg + b_reg);
                            r_reg <= (r_reg >> 1) + b_reg;
                        end else r_reg <= r_reg >> 1;
                        b_reg <= b_reg >> 2;
                    end
                end
                ST_BMUL: begin
                    num_reg <= {64'(mp[63:0]), 64'd0};
                    den_reg <= spd_reg; rem_reg <= '0; cnt_reg <= '0;
                    st_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (!trial[64]) rem_reg <= trial[63:0];
                    else rem_reg <= {rem_reg[62:0], num_reg[127]};
                    num_reg <= num_reg << 1;
                    quo_reg <= {quo_reg[62:0], !trial[64]};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63) st_reg <= ST_BRK;
                end
                ST_BRK: begin
                    if (quo_reg >= cur_abs) begin
                        if (ax_sel_reg) wvy_reg <= '0; else wvx_reg <= '0;
                    end else if (ax_sel_reg)
                        wvy_reg <= wvy_reg[47] ? -48'(absy - quo_reg) : 48'(absy - quo_reg);
                    else
                        wvx_reg <= wvx_reg[47] ? -48'(absx - quo_reg) : 48'(absx - quo_reg);
                    if (ax_sel_reg) begin
                        ax_sel_reg <= 1'b0; st_reg <= ST_ACC;
                    end else begin
                        ax_sel_reg <= 1'b1; st_reg <= ST_BMUL;
                    end
                end
                ST_ACC: begin
                    if (ax_sel_reg) begin
                        wvy_reg <= wvy_reg + rnd_dt(mp);
                        ax_sel_reg <= 1'b0; st_reg <= ST_POS;
                        qx_reg <= px_reg; qy_reg <= py_reg;
                    end else begin
                        wvx_reg <= wvx_reg + rnd_dt(mp); ax_sel_reg <= 1'b1;
                    end
                end
                ST_POS: begin
                    if (ax_sel_reg) begin
                        py_reg <= sat(49'(py_reg) + 49'(rnd_dt(mp)));
                        ax_sel_reg <= 1'b0; st_reg <= ST_CLAMP;
                    end else begin
                        px_reg <= sat(49'(px_reg) + 49'(rnd_dt(mp)));
                        ax_sel_reg <= 1'b1;
                    end
                end
                ST_CLAMP: begin
                    vx_reg <= sat((wvx_reg > vmax_s) ?
                        ((vmax_s < vmin_s) ? 49'(vmin_s) : 49'(vmax_s)) :
                        (wvx_reg < vmin_s) ? 49'(vmin_s) : 49'(wvx_reg));
                    vy_reg <= sat((wvy_reg > vmax_s) ?
                        ((vmax_s < vmin_s) ? 49'(vmin_s) : 49'(vmax_s)) :
                        (wvy_reg < vmin_s) ? 49'(vmin_s) : 49'(wvy_reg));
                    st_reg <= ST_OUT;
                end
                ST_FDIV: begin
                    if (!trial[64]) rem_reg <= trial[63:0];
                    else rem_reg <= {rem_reg[62:0], num_reg[127]};
                    num_reg <= num_reg << 1;
                    quo_reg <= {quo_reg[62:0], !trial[64]};
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127) st_reg <= ST_FAPP;
                end
                ST_FAPP: begin
                    begin : fapp
                        logic signed [31:0] f, q;
                        logic [63:0] qq;
                        f = ax_sel_reg ? iy_reg : ix_reg;
                        qq = (quo_reg > (64'd1 << 40)) ? (64'd1 << 40) : quo_reg;
                        if (f == 0) q = '0;
                        else if (mass_reg == 0) q = f[31] ? 32'sh80000000 : 32'sh7fffffff;
                        else q = sat(f[31] ? -49'(qq) : 49'(qq));
                        if (sub_reg == 2'd0) begin
                            if (ax_sel_reg) ay_reg <= q; else ax_reg <= q;
                            sub_reg <= 2'd1;
                        end else if (ax_sel_reg) begin
                            vy_reg <= sat(49'(vy_reg) + 49'(rnd_dt(mp)));
                            ax_reg <= '0; ay_reg <= '0; st_reg <= ST_OUT;
                        end else begin
                            vx_reg <= sat(49'(vx_reg) + 49'(rnd_dt(mp)));
                            ax_sel_reg <= 1'b1; sub_reg <= '0; cnt_reg <= '0;
                            rem_reg <= '0; ax_reg <= '0; st_reg <= ST_FDIV;
                            num_reg <= {64'd0, 64'(iy_reg[31] ? -33'(iy_reg) :
                                33'(iy_reg)) << FRAC_BITS};
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid || m_tready) begin
                        m_tvalid <= 1'b1; st_reg <= ST_IDLE;
                        m_tdata <= {vy_reg, vx_reg, qy_reg, qx_reg, py_reg, px_reg};
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the point-mass friction step core: directed table plus random words.
`timescale 1ns / 1ps
module tb;
    import pmfs_pkg::*;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [15:0]        dt;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               typed;
        logic [191:0]       result;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [191:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_wdata = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          err_count = 0;
    int          quiet_cycles = 0;
    logic [191:0] state_queue[$];

    logic [30:0]        mdl_mass;
    logic [30:0]        mdl_fric;
    logic [30:0]        mdl_vmax;
    logic signed [31:0] mdl_vmin;
    logic signed [31:0] mdl_pos_x, mdl_pos_y, mdl_prev_x, mdl_prev_y;
    logic signed [31:0] mdl_vel_x, mdl_vel_y, mdl_acc_x, mdl_acc_y;

    string field_names[6] = '{"pos_x_out", "pos_y_out", "prev_x_out", "prev_y_out",
                              "vel_x_out", "vel_y_out"};

    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    point_mass_friction_step_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic logic signed [31:0] clip32(longint v);
        if (v > longint'(S32_MAX)) return S32_MAX;
        if (v < longint'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    // round(a*dt/2^16), ties up
    function automatic longint scale_dt(longint a, logic [15:0] dt);
        longint p;
        p = a * longint'({48'd0, dt}) + 32768;
        return p >>> 16;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint slow_axis(longint v, longint unsigned fm,
                                         longint unsigned speed);
        longint unsigned a, c;
        if (v == 0) return 0;
        a = v < 0 ? longint'(-v) : v;
        c = fm * a / speed;
        if (c >= a) return 0;
        return v < 0 ? -longint'(a - c) : longint'(a - c);
    endfunction

    function automatic logic signed [31:0] force_per_mass(logic signed [31:0] f);
        longint unsigned a, q;
        if (f == 0) return 0;
        if (mdl_mass == 0) return f < 0 ? S32_MIN : S32_MAX;
        a = f < 0 ? longint'(-longint'(f)) : longint'(f);
        q = (a << 16) / {33'd0, mdl_mass};
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return clip32(f < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic logic [191:0] motion_step(logic [1:0] cmd, logic [15:0] dt,
                                                 logic signed [31:0] x,
                                                 logic signed [31:0] y);
        longint vx, vy;
        longint unsigned fa, fm, ax, ay, speed;
        case (cmd)
            CMD_TICK: begin
                vx = mdl_vel_x;
                vy = mdl_vel_y;
                if (vx != 0 || vy != 0) begin
                    fa = ({33'd0, mdl_fric} * {48'd0, dt} + 64'd32768) >> 16;
                    fm = (fa * 64'(GRAVITY_Q24) + (64'd1 << 23)) >> 24;
                    ax = vx < 0 ? -vx : vx;
                    ay = vy < 0 ? -vy : vy;
                    speed = root_floor(ax * ax + ay * ay);
                    if (fm >= speed) begin
                        vx = 0;
                        vy = 0;
                    end else begin
                        vx = slow_axis(vx, fm, speed);
                        vy = slow_axis(vy, fm, speed);
                    end
                end
                vx += scale_dt(mdl_acc_x, dt);
                vy += scale_dt(mdl_acc_y, dt);
                mdl_prev_x = mdl_pos_x;
                mdl_prev_y = mdl_pos_y;
                mdl_pos_x = clip32(longint'(mdl_pos_x) + scale_dt(vx, dt));
                mdl_pos_y = clip32(longint'(mdl_pos_y) + scale_dt(vy, dt));
                if (vx > longint'({33'd0, mdl_vmax})) vx = longint'({33'd0, mdl_vmax});
                if (vx < longint'(mdl_vmin)) vx = longint'(mdl_vmin);
                if (vy > longint'({33'd0, mdl_vmax})) vy = longint'({33'd0, mdl_vmax});
                if (vy < longint'(mdl_vmin)) vy = longint'(mdl_vmin);
                mdl_vel_x = clip32(vx);
                mdl_vel_y = clip32(vy);
            end
            CMD_SETPOS: begin
                mdl_pos_x = x;
                mdl_pos_y = y;
            end
            CMD_FORCE: begin
                mdl_vel_x = clip32(longint'(mdl_vel_x) + scale_dt(force_per_mass(x), dt));
                mdl_vel_y = clip32(longint'(mdl_vel_y) + scale_dt(force_per_mass(y), dt));
                mdl_acc_x = 0;
                mdl_acc_y = 0;
            end
            default: begin
                mdl_acc_x = x;
                mdl_acc_y = y;
            end
        endcase
        return {mdl_vel_y, mdl_vel_x, mdl_prev_y, mdl_prev_x, mdl_pos_y, mdl_pos_x};
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h001fffff)) - 32'sh00100000;
            2: return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
            3: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
            default: return $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
        endcase
    endfunction

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        logic [191:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (state_queue.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                err_count++;
            end else begin
                want = state_queue.pop_front();
                for (int i = 0; i < 6; i++) begin
                    if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
                        $error("%s expected %0d got %0d", field_names[i],
                               $signed(want[32*i +: 32]), $signed(m_tdata[32*i +: 32]));
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= 20000) begin
            $display("FAIL point_mass_friction_step_core");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [15:0] dt, logic signed [31:0] x,
                             logic signed [31:0] y, logic typed, logic [191:0] result);
        logic [191:0] predicted;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {y, x, dt};
        do @(posedge aclk); while (!s_tready);
        predicted = motion_step(cmd, dt, x, y);
        state_queue.push_back(typed ? result : predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (state_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MASS: mdl_mass = value[30:0];
            REG_FRIC: mdl_fric = value[30:0];
            REG_VMAX: mdl_vmax = value[30:0];
            default:  mdl_vmin = value;
        endcase
    endtask

    task automatic random_words(int count);
        logic [1:0]  cmd;
        logic [15:0] dt;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 19))
                0, 1, 2:    cmd = CMD_SETPOS;
                3, 4, 5:    cmd = CMD_SETACC;
                6, 7, 8, 9: cmd = CMD_FORCE;
                default:    cmd = CMD_TICK;
            endcase
            dt = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4000));
            send_word(cmd, dt, pick_value(), pick_value(), 1'b0, '0);
            if (n == count / 2 && count > 50) wait_drained();
        end
    endtask

    stim_row_t directed_rows[18] = '{
        '{CMD_TICK,   16'hffff, 32'sd0, 32'sd0, 1'b1, 192'd0},
        '{CMD_SETPOS, 16'd0, S32_MAX, S32_MIN, 1'b1, {128'd0, S32_MIN, S32_MAX}},
        '{CMD_SETPOS, 16'd0, 32'sd0, 32'sd0, 1'b1, 192'd0},
        '{CMD_SETACC, 16'hffff, 32'sd655360, -32'sd655360, 1'b1, 192'd0},
        '{CMD_TICK,   16'hffff, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_TICK,   16'h8000, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_TICK,   16'd0, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_FORCE,  16'hffff, S32_MAX, S32_MIN, 1'b0, 192'd0},
        '{CMD_TICK,   16'hffff, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_FORCE,  16'h0001, 32'sd0, -32'sd1, 1'b0, 192'd0},
        '{CMD_SETACC, 16'd0, S32_MAX, S32_MAX, 1'b0, 192'd0},
        '{CMD_SETPOS, 16'd0, S32_MAX - 32'sd10, S32_MIN + 32'sd10, 1'b0, 192'd0},
        '{CMD_TICK,   16'hffff, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_SETACC, 16'd0, S32_MIN, S32_MIN, 1'b0, 192'd0},
        '{CMD_TICK,   16'hffff, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_SETACC, 16'd0, 32'sd0, 32'sd0, 1'b0, 192'd0},
        '{CMD_FORCE,  16'h4000, 32'sd65536, -32'sd131072, 1'b0, 192'd0},
        '{CMD_TICK,   16'h1000, 32'sd0, 32'sd0, 1'b0, 192'd0}
    };

    initial begin
        mdl_mass = MASS_RST;
        mdl_fric = '0;
        mdl_vmax = VMAX_RST;
        mdl_vmin = VMIN_RST;
        {mdl_pos_x, mdl_pos_y, mdl_prev_x, mdl_prev_y} = '0;
        {mdl_vel_x, mdl_vel_y, mdl_acc_x, mdl_acc_y} = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].cmd, directed_rows[i].dt, directed_rows[i].vx,
                      directed_rows[i].vy, directed_rows[i].typed, directed_rows[i].result);
        end
        wait_drained();

        // friction large enough to stop, then inverted limits and extreme mass
        write_reg(REG_FRIC, 32'h7fffffff);
        send_word(CMD_FORCE, 16'hffff, 32'sd6553600, 32'sd3276800, 1'b0, '0);
        send_word(CMD_TICK, 16'hffff, 32'sd0, 32'sd0, 1'b0, '0);
        wait_drained();
        write_reg(REG_FRIC, 32'd32768);
        write_reg(REG_VMAX, 32'd0);
        write_reg(REG_VMIN, 32'h80000000);
        write_reg(REG_MASS, 32'd1);
        send_word(CMD_FORCE, 16'h0100, 32'sd3, -32'sd5, 1'b0, '0);
        send_word(CMD_TICK, 16'h0100, 32'sd0, 32'sd0, 1'b0, '0);
        wait_drained();
        write_reg(REG_VMAX, 32'd65536);
        write_reg(REG_VMIN, 32'd131072);
        write_reg(REG_MASS, 32'd0);
        send_word(CMD_FORCE, 16'h0100, 32'sd3, 32'sd0, 1'b0, '0);
        send_word(CMD_FORCE, 16'h0100, -32'sd3, 32'sd0, 1'b0, '0);
        send_word(CMD_TICK, 16'h0100, 32'sd0, 32'sd0, 1'b0, '0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            case (ph)
                0: begin
                    write_reg(REG_MASS, 32'(MASS_RST));
                    write_reg(REG_FRIC, 32'd19660);
                    write_reg(REG_VMAX, 32'(VMAX_RST));
                    write_reg(REG_VMIN, VMIN_RST);
                end
                1: begin
                    write_reg(REG_MASS, 32'h7fffffff);
                    write_reg(REG_FRIC, 32'd0);
                    write_reg(REG_VMAX, 32'h7fffffff);
                    write_reg(REG_VMIN, 32'h80000000);
                end
                2: begin
                    write_reg(REG_MASS, $urandom_range(1, 32'h00ffffff));
                    write_reg(REG_FRIC, $urandom_range(0, 32'h0007ffff));
                    write_reg(REG_VMAX, $urandom_range(0, 32'h7fffffff));
                    write_reg(REG_VMIN, -$urandom_range(0, 32'h7fffffff));
                end
                default: begin
                    write_reg(REG_MASS, $urandom_range(1, 32'h7fffffff));
                    write_reg(REG_FRIC, $urandom);
                    write_reg(REG_VMAX, $urandom_range(0, 32'h0fffffff));
                    write_reg(REG_VMIN, -$urandom_range(0, 32'h0fffffff));
                end
            endcase
            random_words(110);
            wait_drained();
        end

        repeat (300) @(posedge aclk);
        if (err_count == 0 && state_queue.size() == 0) begin
            $display("PASS point_mass_friction_step_core");
        end else begin
            $display("FAIL point_mass_friction_step_core");
        end
        $finish;
    end
endmodule
